@@ hw/rtl/smt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Shared widths, constants and the exp table for the softmax block.
// ----------------------------------------------------------------------------
package smt_pkg;
    localparam int MAX_LEN   = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int LOGIT_W   = 16;
    localparam int PROB_W    = 16;
    localparam int TEMP_W    = 16;
    localparam int EXP_W     = 17;
    localparam int TOTAL_W   = 23;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    function automatic logic [16:0] pow2_lut(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44377;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/smt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smt_in_if / smt_out_if
// Valid/ready channels for logit words and probability words.
// ----------------------------------------------------------------------------
interface smt_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] logit;
    logic               last_in;
    modport source (output valid, output logit, output last_in, input ready);
    modport sink   (input valid, input logit, input last_in, output ready);
endinterface

interface smt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] probability;
    logic [5:0]  position;
    logic        last_out;
    logic        overflowed;
    modport source (output valid, output probability, output position,
                    output last_out, output overflowed, input ready);
    modport sink   (input valid, input probability, input position,
                    input last_out, input overflowed, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/smt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smt_ram
// Generic single-port RAM, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module smt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/smt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smt_div
// Restoring divider, one quotient bit a cycle: round(e*65536/total).
// ----------------------------------------------------------------------------
module smt_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [16:0]          i_exp,
    input  wire logic [22:0]          i_total,
    output logic                      o_done,
    output logic [15:0]               o_prob
);
    import smt_pkg::*;

    // dividend = e*65536 + total/2, 34 bits; quotient fits 18 bits
    logic [33:0] r_num;
    logic [23:0] r_rem;
    logic [17:0] r_quo;
    logic [5:0]  r_bit;
    logic        r_busy;
    logic [23:0] n_trial;
    logic [23:0] n_shift;

    assign n_shift = {r_rem[22:0], r_num[33]};
    assign n_trial = n_shift - {1'b0, i_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {1'b0, i_exp, 16'd0} + {12'd0, i_total[22:1]};
                r_rem  <= '0;
                r_quo  <= '0;
                r_bit  <= 6'd34;
            end else if (r_busy) begin
                r_num <= {r_num[32:0], 1'b0};
                if (!n_trial[23]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[16:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[16:0], 1'b0};
                end
                r_bit <= r_bit - 6'd1;
                if (r_bit == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prob = (r_quo > 18'd65535) ? 16'hFFFF : r_quo[15:0];
endmodule
`default_nettype wire

@@ hw/rtl/softmax_temperature_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// softmax_temperature_top
// Streaming softmax with temperature over up to 64 Q8.8 logits.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_in      in   logit, last_in
//  m_out     out  probability, position, last_out, overflowed
//  cfg       in   i_cfg_we, i_cfg_data (inv_temperature)
//
//  Loading: one word a cycle while not busy; logits go to the store RAM.
//  On the last word: exp pass, per element addr, read, mult, exp, interp.
//  Divide pass: per element an exp recompute, the divider, then the output
//  word, held while m_out is stalled; the divider sets the run time and
//  elements are handled one at a time.
//  Reset (synchronous) clears count, max, total and flag; RAM is not cleared.
// ----------------------------------------------------------------------------
module softmax_temperature_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [smt_pkg::TEMP_W-1:0] i_cfg_data,
    smt_in_if.sink     s_in,
    smt_out_if.source  m_out
);
    import smt_pkg::*;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         r_state;
    logic [TEMP_W-1:0]  r_inv_t;
    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_max;
    logic [TOTAL_W-1:0] r_total;
    logic               r_drop;
    logic [IDX_W-1:0]   r_idx;
    logic [2:0]         r_ph;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [EXP_W-1:0]   ram_rd;
    logic               acc;
    logic               store_ok;

    smt_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({s_in.logit[15], s_in.logit}),
        .o_rdata(ram_rd)
    );

    assign s_in.ready = (r_state == ST_LOAD);
    assign acc        = s_in.valid && s_in.ready;
    assign store_ok   = (r_count < CNT_W'(MAX_LEN));
    assign ram_we     = acc && store_ok;
    assign ram_addr   = (r_state == ST_LOAD) ? r_count[IDX_W-1:0] : r_idx;

    // exp pipeline: ph1 ram out, ph2 product, ph3 log2e product, ph4 table fetch and result
    logic [16:0] r_diff;
    logic [32:0] r_m;
    logic [49:0] r_u;
    logic [16:0] tab_a;
    logic [16:0] tab_b;
    logic [11:0] frac_r;
    logic [16:0] shift_k;
    logic [16:0] n_sub;
    logic [28:0] n_prod;
    logic [16:0] n_val;
    logic [16:0] n_exp;
    logic [49:0] n_u;

    assign n_u    = 50'(r_m) * 50'(LOG2E_Q16);
    assign n_prod = 29'(tab_a - tab_b) * 29'(frac_r);
    assign n_sub  = 17'((n_prod + 29'd2048) >> 12);
    assign n_val  = tab_a - n_sub;

    always_comb begin
        if (shift_k >= 17'd17) begin
            n_exp = '0;
        end else if (shift_k == 17'd0) begin
            n_exp = n_val;
        end else begin
            n_exp = 17'(({1'b0, n_val} + (18'd1 << (shift_k[4:0] - 5'd1))) >> shift_k[4:0]);
        end
    end

    logic        div_start;
    logic        div_done;
    logic [15:0] div_prob;

    // exp is valid combinationally in ph4, the cycle the divider starts
    smt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_exp  (n_exp),
        .i_total(r_total),
        .o_done (div_done),
        .o_prob (div_prob)
    );

    assign div_start = (r_state == ST_DIV) && (r_ph == 3'd4);

    logic r_ovalid;
    assign m_out.valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_inv_t  <= 16'd256;
            r_count  <= '0;
            r_max    <= -16'sd32768;
            r_total  <= '0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
            r_ph     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inv_t <= i_cfg_data;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (acc) begin
                        if (store_ok) begin
                            r_count <= r_count + CNT_W'(1);
                            if (s_in.logit > r_max) begin
                                r_max <= s_in.logit;
                            end
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (s_in.last_in) begin
                            r_idx   <= '0;
                            r_ph    <= '0;
                            r_total <= '0;
                            if (r_count == '0 && !store_ok) begin
                                r_state <= ST_LOAD;
                            end else if (r_count == '0 && store_ok) begin
                                r_state <= ST_EXP;
                            end else begin
                                r_state <= ST_EXP;
                            end
                        end
                    end
                end
                ST_EXP, ST_DIV: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd4) begin
                        r_ph <= '0;
                        if (r_state == ST_EXP) begin
                            r_total <= r_total + TOTAL_W'(n_exp);
                            if ({1'b0, r_idx} == r_count - CNT_W'(1)) begin
                                r_idx   <= '0;
                                r_state <= ST_DIV;
                            end else begin
                                r_idx <= r_idx + IDX_W'(1);
                            end
                        end else begin
                            r_state <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (div_done) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        r_ovalid <= 1'b0;
                        if ({1'b0, r_idx} == r_count - CNT_W'(1)) begin
                            r_state <= ST_LOAD;
                            r_count <= '0;
                            r_max   <= -16'sd32768;
                            r_total <= '0;
                            r_drop  <= 1'b0;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= ST_DIV;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // exp datapath registers, payload only
    always_ff @(posedge i_clk) begin
        if (r_ph == 3'd1) begin
            r_diff <= 17'({r_max[15], r_max} - ram_rd);
        end
        if (r_ph == 3'd2) begin
            r_m <= 33'(r_diff) * 33'(r_inv_t);
        end
        if (r_ph == 3'd3) begin
            r_u <= n_u + 50'd32768;
        end
    end

    // table fetch is combinational from r_u once it is registered
    always_comb begin
        logic [33:0] u_sh;
        u_sh    = 34'(r_u >> 16);
        shift_k = (u_sh[33:16] >= 18'd17) ? 17'd17 : {12'd0, u_sh[20:16]};
        tab_a   = pow2_lut({1'b0, u_sh[15:12]});
        tab_b   = pow2_lut(5'({1'b0, u_sh[15:12]} + 5'd1));
        frac_r  = u_sh[11:0];
    end

    assign m_out.probability = div_prob;
    assign m_out.position    = r_idx;
    assign m_out.last_out    = ({1'b0, r_idx} == r_count - CNT_W'(1));
    assign m_out.overflowed  = r_drop;
endmodule
`default_nettype wire

@@ bench/softmax_temperature_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softmax_temperature_tb_if
// The bench reuses the block's own channel interfaces (smt_in_if and
// smt_out_if). This file holds the small shared record types for expected
// probability words and for logit words.
// ----------------------------------------------------------------------------
package smt_tb_pkg;
    typedef struct packed {
        logic [15:0] probability;
        logic [5:0]  position;
        logic        last_out;
        logic        overflowed;
    } t_prob_word;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last_in;
    } t_logit_word;
endpackage

@@ bench/softmax_temperature_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softmax_temperature_top_tb
// Self-checking bench: feeds logit vectors with random idling on both
// channels, predicts every probability word and compares them in order.
// ----------------------------------------------------------------------------
module softmax_temperature_top_tb;
    import smt_pkg::*;
    import smt_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    localparam logic [15:0] TEMPS [6] = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd64,
                                          16'd1024};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    smt_in_if  s_in();
    smt_out_if m_out();

    softmax_temperature_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .s_in(s_in.sink), .m_out(m_out.source)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [15:0]        inv_temp = 16'd256;
    logic signed [15:0] logit_store [64];
    int unsigned        vec_len = 0;
    logic signed [15:0] vec_max = -16'sd32768;
    logic               vec_dropped = 1'b0;

    t_logit_word pending_words [$];
    t_prob_word  expected_probs [$];

    int mismatches = 0;
    int checked = 0;
    int vectors_done = 0;
    int cycles = 0;
    bit idle_free = 1'b0;
    bit hold_sender = 1'b0;

    localparam logic [16:0] POW2 [17] = '{17'd65536, 17'd62757, 17'd60097, 17'd57549,
        17'd55109, 17'd52773, 17'd50535, 17'd48393, 17'd46341, 17'd44377, 17'd42495,
        17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768};

    function automatic logic [16:0] exp_of_gap(logic [16:0] gap, logic [15:0] itemp);
        logic [63:0] m, u;
        logic [31:0] f, j, r, a, b, val;
        m = 64'(gap) * 64'(itemp);
        u = (m * 64'd94548 + 64'd32768) >> 16;
        if ((u >> 16) >= 17) return '0;
        f = 32'(u[15:0]);
        j = f >> 12;
        r = f & 32'hFFF;
        a = 32'(POW2[j]);
        b = 32'(POW2[j + 1]);
        val = a - (((a - b) * r + 32'd2048) >> 12);
        if (u[31:16] > 0)
            val = (val + (32'd1 << (u[31:16] - 1))) >> u[31:16];
        return val[16:0];
    endfunction

    task automatic absorb_logit(t_logit_word w);
        logic [31:0] total;
        logic [63:0] p;
        logic [16:0] e;
        t_prob_word  pw;
        if (vec_len < MAX_LEN) begin
            logit_store[6'(vec_len)] = w.logit;
            if (w.logit > vec_max) vec_max = w.logit;
            vec_len++;
        end else begin
            vec_dropped = 1'b1;
        end
        if (!w.last_in) return;
        total = 0;
        for (int i = 0; i < vec_len; i++)
            total += exp_of_gap(17'(32'(vec_max) - 32'(logit_store[6'(i)])), inv_temp);
        for (int i = 0; i < vec_len; i++) begin
            e = exp_of_gap(17'(32'(vec_max) - 32'(logit_store[6'(i)])), inv_temp);
            p = (64'(e) * 64'd65536 + 64'(total >> 1)) / 64'(total);
            if (p > 65535) p = 65535;
            pw.probability = p[15:0];
            pw.position = 6'(i);
            pw.last_out = (i + 1 == vec_len);
            pw.overflowed = vec_dropped;
            expected_probs.push_back(pw);
        end
        vec_len = 0;
        vec_max = -16'sd32768;
        vec_dropped = 1'b0;
    endtask

    // driver
    initial begin
        s_in.valid = 1'b0;
        s_in.logit = '0;
        s_in.last_in = 1'b0;
        m_out.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_logit_word w;
        if (i_rst_n) begin
            if (s_in.valid && s_in.ready) begin
                w.logit = s_in.logit;
                w.last_in = s_in.last_in;
                absorb_logit(w);
                void'(pending_words.pop_front());
            end
            // a word still waiting for ready is held as it is
            if (!(s_in.valid && !s_in.ready)) begin
                if (hold_sender || pending_words.size() == 0 ||
                    (!idle_free && $urandom_range(99) < 16)) begin
                    s_in.valid <= 1'b0;
                end else begin
                    // next word is at the queue head after the pop above
                    s_in.valid <= 1'b1;
                    s_in.logit <= pending_words[0].logit;
                    s_in.last_in <= pending_words[0].last_in;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_prob_word got, want;
        if (i_rst_n) begin
            if (m_out.valid && m_out.ready) begin
                got = '{m_out.probability, m_out.position, m_out.last_out,
                        m_out.overflowed};
                checked++;
                if (expected_probs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: prob %0d pos %0d",
                                 got.probability, got.position);
                end else begin
                    want = expected_probs.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp p%0d i%0d l%0b o%0b got p%0d i%0d l%0b o%0b",
                                want.probability, want.position, want.last_out,
                                want.overflowed, got.probability, got.position,
                                got.last_out, got.overflowed);
                    end
                    if (got.last_out) vectors_done++;
                end
            end
            m_out.ready <= idle_free || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("softmax_temperature_top regression: fail");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_logit();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(32767) - 16384);
            2: return 16'($urandom_range(1023) - 512);
            default: return $urandom_range(1) ? 16'sh7FFF : -16'sd32768;
        endcase
    endfunction

    task automatic queue_vector(int len, bit wide);
        t_logit_word w;
        for (int i = 0; i < len; i++) begin
            w.logit = wide ? rand_logit() : 16'($urandom_range(2047) - 1024);
            w.last_in = (i == len - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || expected_probs.size() != 0 || s_in.valid)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_temp(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        inv_temp = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_logit_word w;
        int total_items;
        int tail_len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single element, ties, full vector with drops
        w = '{16'sh7FFF, 1'b0}; pending_words.push_back(w);
        w = '{-16'sd32768, 1'b0}; pending_words.push_back(w);
        w = '{16'sd0, 1'b1}; pending_words.push_back(w);
        w = '{16'sd100, 1'b1}; pending_words.push_back(w);
        w = '{16'sd5, 1'b0}; pending_words.push_back(w);
        w = '{16'sd5, 1'b1}; pending_words.push_back(w);
        w = '{16'shAAAA, 1'b0}; pending_words.push_back(w);
        w = '{16'sh5555, 1'b1}; pending_words.push_back(w);
        settle();
        queue_vector(66, 1'b0); // two words dropped, last one closes the vector
        settle();
        queue_vector(64, 1'b1);
        w = '{16'sd7, 1'b1}; pending_words.push_back(w); // lone closer, a one-word vector of its own
        settle();

        total_items = 139;
        for (int t = 0; t < 6; t++) begin
            write_temp(TEMPS[t]);
            idle_free = (t == 2);
            for (int v = 0; v < 4; v++) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(64, 60)
                                               : $urandom_range(16, 1);
                queue_vector(len, $urandom_range(1));
                total_items += len;
                if (v == 2) begin
                    // sender waits until the block has drained
                    while (pending_words.size() != 0 || s_in.valid) @(posedge i_clk);
                    hold_sender = 1'b1;
                    queue_vector(3, 1'b1);
                    total_items += 3;
                    while (expected_probs.size() != 0) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            settle();
        end
        idle_free = 1'b0;
        while (total_items < 480) begin
            tail_len = $urandom_range(12, 1);
            queue_vector(tail_len, 1'b1);
            total_items += tail_len;
        end
        settle();

        $display("covered %0d vectors, %0d probability words, temps 0..65535",
                 vectors_done, checked);
        if (mismatches == 0 && expected_probs.size() == 0)
            $display("softmax_temperature_top regression: pass");
        else
            $display("softmax_temperature_top regression: fail");
        $finish;
    end
endmodule
